// ===== src/bumc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bumc_pkg
// Shared codes, constants and the brightness table for the one-button unlock
// and menu controller.
// ----------------------------------------------------------------------------
package bumc_pkg;

	typedef logic [1:0] cmd_t;
	typedef logic [2:0] action_t;
	typedef logic [1:0] mode_t;
	typedef logic [2:0] step_t;
	typedef logic [1:0] screen_t;
	typedef logic [2:0] bidx_t;
	typedef logic [7:0] level_t;
	typedef logic [1:0] cfg_idx_t;
	typedef logic [15:0] timeout_t;

	localparam cmd_t CMD_TICK  = 2'd0;
	localparam cmd_t CMD_SHORT = 2'd1;
	localparam cmd_t CMD_LONG  = 2'd2;
	localparam cmd_t CMD_HELD  = 2'd3;

	localparam action_t ACT_NONE    = 3'd0;
	localparam action_t ACT_NEXT    = 3'd1;
	localparam action_t ACT_LOOP    = 3'd2;
	localparam action_t ACT_BRIGHT  = 3'd3;
	localparam action_t ACT_SPECIAL = 3'd4;

	localparam mode_t MODE_NEXT    = 2'd0;
	localparam mode_t MODE_PREV    = 2'd1;
	localparam mode_t MODE_BRIGHT  = 2'd2;
	localparam mode_t MODE_SPECIAL = 2'd3;

	localparam screen_t SCR_BLANK = 2'd0;
	localparam screen_t SCR_LONG  = 2'd1;
	localparam screen_t SCR_SHORT = 2'd2;
	localparam screen_t SCR_MENU  = 2'd3;

	localparam step_t STEP_WAIT_SHORT = 3'd0;
	localparam step_t STEP_RELEASE    = 3'd4;
	localparam step_t STEP_UNLOCKED   = 3'd5;

	localparam cfg_idx_t CFG_IDLE_TIMEOUT = 2'd0;
	localparam cfg_idx_t CFG_STEP_TIMEOUT = 2'd1;

	localparam timeout_t IDLE_TIMEOUT_RESET = 16'd10000;
	localparam timeout_t STEP_TIMEOUT_RESET = 16'd4000;

	function automatic level_t bright_level(input bidx_t idx);
		level_t lvl;
		begin
			case (idx)
				3'd0: lvl = 8'd2;
				3'd1: lvl = 8'd4;
				3'd2: lvl = 8'd8;
				3'd3: lvl = 8'd16;
				3'd4: lvl = 8'd32;
				3'd5: lvl = 8'd64;
				3'd6: lvl = 8'd128;
				default: lvl = 8'd255;
			endcase
			return lvl;
		end
	endfunction

endpackage

// ===== src/button_unlock_menu_controller_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_unlock_menu_controller_core
// One-button gesture controller: six-state unlock sequence with deadlines,
// then a small menu with mode cycling and a wrapping brightness cursor.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | cmd, now_ms, button_down, long_hold_reached
// out     | output    | out_valid / out_ready | action, menu_mode, brightness_level,
//         |           |                       | lock_state, screen_view
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each item is held in the input register and then moves to the result register,
// where its result is presented; one item is taken every cycle while the
// output is drained.
// The state update (one 32-bit add and one wrapping compare) sits between the
// two registers, and the next item sees the state left by the one before it.
// A stalled output holds the result register and then the input register.
// Reset clears the state to locked, next mode and the initial brightness.
// ----------------------------------------------------------------------------
module button_unlock_menu_controller_core #(
	parameter int INITIAL_BRIGHTNESS_INDEX = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  bumc_pkg::cmd_t            cmd,
	input  logic [31:0]               now_ms,
	input  logic                      button_down,
	input  logic                      long_hold_reached,
	output logic                      out_valid,
	input  logic                      out_ready,
	output bumc_pkg::action_t         action,
	output bumc_pkg::mode_t           menu_mode,
	output bumc_pkg::level_t          brightness_level,
	output bumc_pkg::step_t           lock_state,
	output bumc_pkg::screen_t         screen_view,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  bumc_pkg::cfg_idx_t        cfg_index,
	input  bumc_pkg::timeout_t        cfg_data
);
	import bumc_pkg::*;

	timeout_t idle_to_q;
	timeout_t step_to_q;

	logic        valid_s1;
	cmd_t        cmd_s1;
	logic [31:0] now_s1;
	logic        down_s1;
	logic        hold_s1;

	step_t       step_q;
	logic [31:0] deadline_q;
	mode_t       mode_q;
	bidx_t       bidx_q;

	logic        out_valid_q;
	action_t     action_q;
	mode_t       mode_out_q;
	level_t      level_q;
	step_t       step_out_q;
	screen_t     screen_q;

	logic        advance;
	step_t       step_n;
	step_t       step_t1;
	logic [31:0] deadline_n;
	mode_t       mode_n;
	bidx_t       bidx_n;
	action_t     action_n;
	screen_t     screen_n;
	logic [31:0] diff;
	logic [31:0] arm_sum;
	logic        use_idle;
	logic        expired;
	logic        is_long;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_to_q <= IDLE_TIMEOUT_RESET;
			step_to_q <= STEP_TIMEOUT_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_IDLE_TIMEOUT) begin
				idle_to_q <= cfg_data;
			end else if (cfg_index == CFG_STEP_TIMEOUT) begin
				step_to_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1  <= cmd;
			now_s1  <= now_ms;
			down_s1 <= button_down;
			hold_s1 <= long_hold_reached;
		end
	end

	assign diff    = now_s1 - deadline_q;
	assign expired = (step_q != STEP_WAIT_SHORT) && !diff[31];
	assign is_long = (cmd_s1 == CMD_LONG);
	assign step_t1 = expired ? STEP_WAIT_SHORT : step_q;
	assign use_idle = (cmd_s1 == CMD_TICK);
	assign arm_sum = now_s1 + {16'd0, (use_idle ? idle_to_q : step_to_q)};

	always_comb begin
		step_n     = step_q;
		deadline_n = deadline_q;
		mode_n     = mode_q;
		bidx_n     = bidx_q;
		action_n   = ACT_NONE;
		screen_n   = SCR_BLANK;
		case (cmd_s1)
			CMD_TICK: begin
				step_n = step_t1;
				if (step_t1 < STEP_UNLOCKED) begin
					if ((step_t1 == STEP_WAIT_SHORT && !down_s1) || hold_s1 ||
					    step_t1 >= STEP_RELEASE) begin
						screen_n = SCR_BLANK;
					end else if (step_t1[0]) begin
						screen_n = SCR_LONG;
					end else begin
						screen_n = SCR_SHORT;
					end
					if (step_t1 >= STEP_RELEASE && !down_s1) begin
						step_n     = STEP_UNLOCKED;
						deadline_n = arm_sum;
						screen_n   = SCR_MENU;
					end
				end else begin
					if (down_s1) begin
						deadline_n = arm_sum;
					end
					screen_n = SCR_MENU;
				end
			end
			CMD_SHORT, CMD_LONG: begin
				if (step_q < STEP_UNLOCKED) begin
					if (step_q[0] != is_long) begin
						step_n = STEP_WAIT_SHORT;
					end else begin
						step_n     = step_q + 3'd1;
						deadline_n = arm_sum;
					end
				end
				if (step_n >= STEP_UNLOCKED) begin
					if (is_long) begin
						case (mode_q)
							MODE_NEXT: mode_n = MODE_PREV;
							MODE_PREV: mode_n = MODE_BRIGHT;
							default:   mode_n = MODE_NEXT;
						endcase
					end else begin
						case (mode_q)
							MODE_NEXT: action_n = ACT_NEXT;
							MODE_PREV: action_n = ACT_LOOP;
							MODE_BRIGHT: begin
								bidx_n   = bidx_q + 3'd1;
								action_n = ACT_BRIGHT;
							end
							default: action_n = ACT_SPECIAL;
						endcase
					end
				end
			end
			default: begin
				if (step_q < STEP_UNLOCKED) begin
					step_n = STEP_WAIT_SHORT;
				end else begin
					mode_n = MODE_SPECIAL;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= STEP_WAIT_SHORT;
			deadline_q <= 32'd0;
			mode_q     <= MODE_NEXT;
			bidx_q     <= bidx_t'(INITIAL_BRIGHTNESS_INDEX);
		end else if (advance) begin
			step_q     <= step_n;
			deadline_q <= deadline_n;
			mode_q     <= mode_n;
			bidx_q     <= bidx_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			action_q   <= action_n;
			mode_out_q <= mode_n;
			level_q    <= bright_level(bidx_n);
			step_out_q <= step_n;
			screen_q   <= screen_n;
		end
	end

	assign out_valid        = out_valid_q;
	assign action           = action_q;
	assign menu_mode        = mode_out_q;
	assign brightness_level = level_q;
	assign lock_state       = step_out_q;
	assign screen_view      = screen_q;

endmodule

// ===== src/bumc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bumc_checker
// Port-level checks on the result channel of the unlock and menu controller.
// ----------------------------------------------------------------------------
module bumc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input bumc_pkg::action_t  action,
	input bumc_pkg::mode_t    menu_mode,
	input bumc_pkg::level_t   brightness_level,
	input bumc_pkg::step_t    lock_state,
	input bumc_pkg::screen_t  screen_view
);
	import bumc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(action) && $stable(menu_mode) &&
			$stable(brightness_level) && $stable(lock_state) && $stable(screen_view))
		else $error("Result item changed while stalled.");

	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> lock_state <= STEP_UNLOCKED)
		else $error("Lock state outside the unlock sequence.");

	a_action_unlocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action != ACT_NONE |-> lock_state == STEP_UNLOCKED &&
			screen_view == SCR_BLANK)
		else $error("Action given while locked or on a tick.");

	a_bright_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == ACT_BRIGHT |-> menu_mode == MODE_BRIGHT)
		else $error("Brightness stepped outside brightness mode.");

	a_level_table: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot(brightness_level) || brightness_level == 8'd255)
		else $error("Brightness level not in the table.");

endmodule

bind button_unlock_menu_controller_core bumc_checker u_bumc_checker (.*);
